[hdl/pai_pkg.sv]
// Shared constants and types for the polygon area and point-inside core.
package pai_pkg;

    localparam int COORD_BITS   = 24;
    localparam int MAX_VERTICES = 1024;
    localparam int MIN_VERTICES = 3;
    localparam int AREA_W       = 59;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = AREA_W + 1;
    localparam int XI_W   = DIFF_W + 2;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int STEP_W = $clog2(DIFF_W);
    localparam int NUM_MUL = 3;

    localparam int APB_W  = 32;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] REG_TEST_X = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] REG_TEST_Y = ADDR_W'(4);

    localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        LC_DEGEN = 2'd0,
        LC_OUTER = 2'd1,
        LC_HOLE  = 2'd2
    } t_loop_class;

endpackage

[hdl/polygon_area_and_point_inside_core.sv]
// Polygon twice-area and crossing-parity core with bit-serial multiply and divide.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  vertex   | i_in_valid / o_in_stall      | i_vertex_x, i_vertex_y, i_last_vertex
//  result   | o_out_valid / i_out_stall    | o_twice_area, o_inside_res, o_loop_class,
//           |                              | o_too_many
//  config   | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
//  First vertex of a path: stored in the idle state. Every edge: an accept, 25 multiply
//  steps, an accumulate state and a finish state, plus 25 divide steps when the edge
//  straddles test_y. The last vertex also runs the closing edge and then the result
//  state. Edge time is set by the shared shift-add multipliers and the
//  restoring divider.
//  Synchronous active-low reset; no clearing pass after reset.
//  o_in_stall is high while a request is in work; a held result does not block the next
//  vertex until that path's result is due.
module polygon_area_and_point_inside_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [pai_pkg::COORD_BITS-1:0]    i_vertex_x,
    input  logic signed [pai_pkg::COORD_BITS-1:0]    i_vertex_y,
    input  logic                                     i_last_vertex,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [pai_pkg::AREA_W-1:0]        o_twice_area,
    output logic                                     o_inside_res,
    output logic [1:0]                               o_loop_class,
    output logic                                     o_too_many,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [pai_pkg::ADDR_W-1:0]               paddr,
    input  logic [pai_pkg::APB_W-1:0]                pwdata,
    output logic [pai_pkg::APB_W-1:0]                prdata,
    output logic                                     pready
);

    localparam int CW = pai_pkg::COORD_BITS;
    localparam int DW = pai_pkg::DIFF_W;
    localparam int PW = pai_pkg::PROD_W;
    localparam int SW = pai_pkg::SUM_W;
    localparam int AW = pai_pkg::AREA_W;
    localparam int XW = pai_pkg::XI_W;
    localparam int NM = pai_pkg::NUM_MUL;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state n_state, r_state;

    logic signed [CW-1:0] r_test_x, r_test_y;

    logic signed [CW-1:0] r_first_x, r_first_y, n_first_x, n_first_y;
    logic signed [CW-1:0] r_prev_x, r_prev_y, n_prev_x, n_prev_y;
    logic [pai_pkg::CNT_W-1:0] r_count, n_count;
    logic signed [AW-1:0] r_area, n_area;
    logic r_parity, n_parity;
    logic r_overflow, n_overflow;
    logic r_last, n_last;
    logic r_close_pend, n_close_pend;

    logic signed [CW-1:0] r_ex1, n_ex1;
    logic r_straddle, n_straddle;
    logic r_den_neg, n_den_neg;
    logic [DW-1:0] r_den_mag, n_den_mag;

    logic signed [PW-1:0] r_mc [NM];
    logic signed [PW-1:0] n_mc [NM];
    logic [DW-1:0] r_mp [NM];
    logic [DW-1:0] n_mp [NM];
    logic signed [PW-1:0] r_acc [NM];
    logic signed [PW-1:0] n_acc [NM];
    logic signed [PW-1:0] m_add [NM];
    logic [pai_pkg::STEP_W-1:0] r_cnt, n_cnt;

    logic r_neg, n_neg;
    logic [PW-1:0] r_rem, n_rem;
    logic [PW-1:0] r_dsr, n_dsr;
    logic [DW-1:0] r_quo, n_quo;

    logic r_out_valid, n_out_valid;
    logic signed [AW-1:0] r_out_area, n_out_area;
    logic r_out_inside, n_out_inside;
    logic [1:0] r_out_class, n_out_class;
    logic r_out_too_many, n_out_too_many;

    logic e_start;
    logic signed [CW-1:0] e_x1, e_y1, e_x2, e_y2;
    logic signed [DW-1:0] e_den;
    logic signed [DW-1:0] e_a [NM];
    logic signed [DW-1:0] e_b [NM];

    logic signed [SW-1:0] c_cross, c_sum;
    logic signed [AW-1:0] c_area_sat;
    logic c_num_neg;
    logic [PW-1:0] c_num_mag;
    logic [PW:0] c_diff;
    logic signed [XW-1:0] c_q_pos, c_xi;
    logic c_hit;
    logic c_last_step;
    logic c_enough;
    logic cfg_wr;

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_twice_area = r_out_area;
    assign o_inside_res = r_out_inside;
    assign o_loop_class = r_out_class;
    assign o_too_many   = r_out_too_many;

    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == pai_pkg::REG_TEST_Y[2]) ?
                    pai_pkg::APB_W'(r_test_y) : pai_pkg::APB_W'(r_test_x);

    assign c_cross = SW'(r_acc[0]) - SW'(r_acc[1]);
    assign c_sum   = SW'(r_area) + c_cross;
    assign c_area_sat = (c_sum[SW-1] != c_sum[SW-2]) ?
                        (c_sum[SW-1] ? pai_pkg::AREA_MIN : pai_pkg::AREA_MAX) :
                        c_sum[AW-1:0];
    assign c_num_neg = r_acc[2][PW-1];
    assign c_num_mag = c_num_neg ? PW'(-r_acc[2]) : PW'(r_acc[2]);
    assign c_diff    = {1'b0, r_rem} - {1'b0, r_dsr};
    assign c_q_pos   = signed'(XW'(r_quo));
    assign c_xi      = XW'(r_ex1) + (r_neg ? -c_q_pos : c_q_pos);
    assign c_hit     = (XW'(r_test_x) < c_xi);
    assign c_last_step = (r_cnt == pai_pkg::STEP_W'(DW - 1));
    assign c_enough  = (r_count >= pai_pkg::CNT_W'(pai_pkg::MIN_VERTICES));
    assign e_den     = DW'(e_y2) - DW'(e_y1);

    always_comb begin
        n_state      = r_state;
        n_first_x    = r_first_x;
        n_first_y    = r_first_y;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_count      = r_count;
        n_area       = r_area;
        n_parity     = r_parity;
        n_overflow   = r_overflow;
        n_last       = r_last;
        n_close_pend = r_close_pend;
        n_ex1        = r_ex1;
        n_straddle   = r_straddle;
        n_den_neg    = r_den_neg;
        n_den_mag    = r_den_mag;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_rem        = r_rem;
        n_dsr        = r_dsr;
        n_quo        = r_quo;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_area     = r_out_area;
        n_out_inside   = r_out_inside;
        n_out_class    = r_out_class;
        n_out_too_many = r_out_too_many;
        e_start = 1'b0;
        e_x1    = r_prev_x;
        e_y1    = r_prev_y;
        e_x2    = r_first_x;
        e_y2    = r_first_y;
        for (int k = 0; k < NM; k++) begin
            n_mc[k]  = r_mc[k];
            n_mp[k]  = r_mp[k];
            n_acc[k] = r_acc[k];
            m_add[k] = r_mp[k][0] ? r_mc[k] : '0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_prev_x = i_vertex_x;
                    n_prev_y = i_vertex_y;
                    n_last   = i_last_vertex;
                    if (r_count >= pai_pkg::CNT_W'(pai_pkg::MAX_VERTICES)) begin
                        n_overflow = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                    if (r_count != '0) begin
                        e_start      = 1'b1;
                        e_x2         = i_vertex_x;
                        e_y2         = i_vertex_y;
                        n_close_pend = i_last_vertex;
                        n_state      = ST_MUL;
                    end else begin
                        n_first_x = i_vertex_x;
                        n_first_y = i_vertex_y;
                        n_state   = i_last_vertex ? ST_OUT : ST_IDLE;
                    end
                end
            end
            ST_MUL: begin
                for (int k = 0; k < NM; k++) begin
                    n_acc[k] = c_last_step ? r_acc[k] - m_add[k] : r_acc[k] + m_add[k];
                    n_mc[k]  = r_mc[k] <<< 1;
                    n_mp[k]  = r_mp[k] >> 1;
                end
                n_cnt = r_cnt + 1'b1;
                if (c_last_step) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_area  = c_area_sat;
                n_neg   = c_num_neg ^ r_den_neg;
                n_rem   = c_num_mag;
                n_dsr   = PW'(r_den_mag) << (DW - 1);
                n_quo   = '0;
                n_cnt   = '0;
                n_state = r_straddle ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                if (!c_diff[PW]) begin
                    n_rem = c_diff[PW-1:0];
                end
                n_quo = {r_quo[DW-2:0], !c_diff[PW]};
                n_dsr = r_dsr >> 1;
                n_cnt = r_cnt + 1'b1;
                if (c_last_step) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_straddle && c_hit) begin
                    n_parity = !r_parity;
                end
                if (r_close_pend) begin
                    e_start      = 1'b1;
                    n_close_pend = 1'b0;
                    n_state      = ST_MUL;
                end else begin
                    n_state = r_last ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_out_area     = c_enough ? r_area : '0;
                    n_out_inside   = c_enough && r_parity;
                    n_out_too_many = r_overflow;
                    if (!c_enough || r_area == '0) begin
                        n_out_class = pai_pkg::LC_DEGEN;
                    end else if (r_area[AW-1]) begin
                        n_out_class = pai_pkg::LC_HOLE;
                    end else begin
                        n_out_class = pai_pkg::LC_OUTER;
                    end
                    n_first_x  = '0;
                    n_first_y  = '0;
                    n_prev_x   = '0;
                    n_prev_y   = '0;
                    n_count    = '0;
                    n_area     = '0;
                    n_parity   = 1'b0;
                    n_overflow = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // edge (x1,y1) -> (x2,y2): x1*y2, x2*y1, (ty-y1)*(x2-x1)
        e_a[0] = DW'(e_x1);
        e_b[0] = DW'(e_y2);
        e_a[1] = DW'(e_x2);
        e_b[1] = DW'(e_y1);
        e_a[2] = DW'(e_x2) - DW'(e_x1);
        e_b[2] = DW'(r_test_y) - DW'(e_y1);
        if (e_start) begin
            n_ex1      = e_x1;
            n_straddle = (e_y1 > r_test_y) != (e_y2 > r_test_y);
            n_den_neg  = e_den[DW-1];
            n_den_mag  = e_den[DW-1] ? DW'(-e_den) : DW'(e_den);
            n_cnt      = '0;
            for (int k = 0; k < NM; k++) begin
                n_mc[k]  = PW'(e_a[k]);
                n_mp[k]  = e_b[k];
                n_acc[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_test_x     <= '0;
            r_test_y     <= '0;
            r_count      <= '0;
            r_area       <= '0;
            r_parity     <= 1'b0;
            r_overflow   <= 1'b0;
            r_close_pend <= 1'b0;
            r_out_valid  <= 1'b0;
            r_first_x    <= '0;
            r_first_y    <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_area       <= n_area;
            r_parity     <= n_parity;
            r_overflow   <= n_overflow;
            r_close_pend <= n_close_pend;
            r_out_valid  <= n_out_valid;
            r_first_x    <= n_first_x;
            r_first_y    <= n_first_y;
            r_prev_x     <= n_prev_x;
            r_prev_y     <= n_prev_y;
            if (cfg_wr) begin
                if (paddr[2] == pai_pkg::REG_TEST_Y[2]) begin
                    r_test_y <= pwdata[CW-1:0];
                end else begin
                    r_test_x <= pwdata[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last         <= n_last;
        r_ex1          <= n_ex1;
        r_straddle     <= n_straddle;
        r_den_neg      <= n_den_neg;
        r_den_mag      <= n_den_mag;
        r_cnt          <= n_cnt;
        r_neg          <= n_neg;
        r_rem          <= n_rem;
        r_dsr          <= n_dsr;
        r_quo          <= n_quo;
        r_out_area     <= n_out_area;
        r_out_inside   <= n_out_inside;
        r_out_class    <= n_out_class;
        r_out_too_many <= n_out_too_many;
        for (int k = 0; k < NM; k++) begin
            r_mc[k]  <= n_mc[k];
            r_mp[k]  <= n_mp[k];
            r_acc[k] <= n_acc[k];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pai_pkg::CNT_W'(pai_pkg::MAX_VERTICES))
        else $error("vertex count above bound");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> r_count == pai_pkg::CNT_W'(pai_pkg::MAX_VERTICES))
        else $error("overflow flagged before count saturated");

    a_div_straddle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_straddle)
        else $error("divide run on an edge that does not straddle");

    a_empty_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_area == '0 && !r_parity && !r_overflow))
        else $error("path state not clear with no vertices");

    a_class_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_class == pai_pkg::LC_OUTER) |->
        (!r_out_area[AW-1] && r_out_area != '0))
        else $error("outer class with non-positive area");
`endif

endmodule
